@@ rtl/psd_pkg.sv @@
// shared widths, types and status codes for the point to segment distance unit
// no dependencies; used by the top level and its checker

package psd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int WIDE_W      = SUM_W + 3;
    localparam int T_FRAC      = 16;
    localparam int QUO_W       = T_FRAC + 2;
    localparam int T_W         = T_FRAC + 1;
    localparam int TD_W        = T_W + DIFF_W;
    localparam int ADD_W       = TD_W - T_FRAC + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 4;
    localparam int DIST_W      = COORD_WIDTH + 2;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_DEGEN  = 2'd1;
    localparam status_t STATUS_WINDOW = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic        [SUM_W-1:0]       usum_t;
    typedef logic signed [WIDE_W-1:0]      wide_t;
    typedef logic signed [ADD_W-1:0]       add_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // one step of the restoring divider for the projection parameter
    typedef struct {
        status_t          status;
        logic             neg;
        coord_t           p [3];
        coord_t           a [3];
        diff_t            d [3];
        usum_t            den;
        usum_t            rem;
        logic [QUO_W-1:0] quo;
    } div_t;

    // one step of the digit-by-digit square root
    typedef struct {
        status_t           status;
        coord_t            nr [3];
        usum_t             rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

endpackage

@@ rtl/point_segment_distance_unit.sv @@
// point to segment distance in 3-d: closest point on line AB and its distance to P
// depends on psd_pkg
// stage order: a, b, c, d, divider, t, m, n1, n2, e1..e3, sqrt, output; one per register
// one query per cycle unless stalled; 18 divider steps and 26 square root steps are unrolled
// a stalled result freezes the whole pipeline, so result_stall shows up as query_stall
// reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset

module point_segment_distance_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_stall,
    input  psd_pkg::coord_t   point_x,
    input  psd_pkg::coord_t   point_y,
    input  psd_pkg::coord_t   point_z,
    input  psd_pkg::coord_t   start_x,
    input  psd_pkg::coord_t   start_y,
    input  psd_pkg::coord_t   start_z,
    input  psd_pkg::coord_t   end_x,
    input  psd_pkg::coord_t   end_y,
    input  psd_pkg::coord_t   end_z,
    output logic              result_valid,
    input  logic              result_stall,
    output psd_pkg::status_t  status,
    output psd_pkg::coord_t   near_x,
    output psd_pkg::coord_t   near_y,
    output psd_pkg::coord_t   near_z,
    output logic [psd_pkg::DIST_W-1:0] distance
);

    localparam int NUM_STAGES = 4 + psd_pkg::QUO_W + 4 + 3 + psd_pkg::ROOT_W + 1;

    logic                  adv;
    logic [NUM_STAGES-1:0] vld_reg;

    psd_pkg::coord_t in_p [3];
    psd_pkg::coord_t in_a [3];
    psd_pkg::coord_t in_b [3];

    // stage a: differences
    psd_pkg::coord_t sa_p_reg  [3];
    psd_pkg::coord_t sa_a_reg  [3];
    psd_pkg::diff_t  sa_d_reg  [3];
    psd_pkg::diff_t  sa_pa_reg [3];
    // stage b: products
    psd_pkg::coord_t sb_p_reg  [3];
    psd_pkg::coord_t sb_a_reg  [3];
    psd_pkg::diff_t  sb_d_reg  [3];
    psd_pkg::prod_t  sb_dd_reg [3];
    psd_pkg::prod_t  sb_dp_reg [3];
    // stage c: sums
    psd_pkg::coord_t sc_p_reg  [3];
    psd_pkg::coord_t sc_a_reg  [3];
    psd_pkg::diff_t  sc_d_reg  [3];
    psd_pkg::sum_t   sc_len_reg;
    psd_pkg::sum_t   sc_dot_reg;
    // stage d: window test and divider setup
    psd_pkg::div_t   sd_next;
    psd_pkg::div_t   sd_reg;
    psd_pkg::wide_t  dot2;
    psd_pkg::wide_t  len1;
    psd_pkg::wide_t  len3;
    // divider steps
    psd_pkg::div_t   div_reg [psd_pkg::QUO_W];
    // stage t: rounded parameter and magnitudes
    psd_pkg::status_t            st_status_reg;
    psd_pkg::coord_t             st_p_reg    [3];
    psd_pkg::coord_t             st_a_reg    [3];
    logic [psd_pkg::T_W-1:0]     st_tmag_reg;
    logic [psd_pkg::DIFF_W-1:0]  st_dmag_reg [3];
    logic                        st_sgn_reg  [3];
    logic [psd_pkg::QUO_W:0]     t_sum;
    // stage m: t times d
    psd_pkg::status_t            sm_status_reg;
    psd_pkg::coord_t             sm_p_reg    [3];
    psd_pkg::coord_t             sm_a_reg    [3];
    logic [psd_pkg::TD_W-1:0]    sm_prod_reg [3];
    logic                        sm_sgn_reg  [3];
    // stage n1: rounded signed offset
    psd_pkg::status_t            sn1_status_reg;
    psd_pkg::coord_t             sn1_p_reg   [3];
    psd_pkg::coord_t             sn1_a_reg   [3];
    psd_pkg::add_t               sn1_off_reg [3];
    psd_pkg::add_t               off_next    [3];
    logic [psd_pkg::TD_W:0]      rnd_sum     [3];
    // stage n2: saturated closest point
    psd_pkg::status_t            sn2_status_reg;
    psd_pkg::coord_t             sn2_p_reg   [3];
    psd_pkg::coord_t             sn2_nr_reg  [3];
    psd_pkg::coord_t             nr_next     [3];
    psd_pkg::add_t               pos_sum     [3];
    // stage e1..e3: error vector, squares, radicand
    psd_pkg::status_t            se1_status_reg;
    psd_pkg::coord_t             se1_nr_reg  [3];
    psd_pkg::diff_t              se1_e_reg   [3];
    psd_pkg::status_t            se2_status_reg;
    psd_pkg::coord_t             se2_nr_reg  [3];
    psd_pkg::prod_t              se2_sq_reg  [3];
    psd_pkg::sqrt_t              se3_reg;
    // square root steps
    psd_pkg::sqrt_t              sqrt_reg [psd_pkg::ROOT_W];
    // output stage
    logic [psd_pkg::ROOT_W:0]    dist_sum;
    logic [psd_pkg::DIST_W-1:0]  dist_next;
    psd_pkg::status_t            out_status_reg;
    psd_pkg::coord_t             out_near_reg [3];
    logic [psd_pkg::DIST_W-1:0]  out_dist_reg;

    assign adv         = !(result_valid && result_stall);
    assign query_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], query_valid};
        end
    end

    always_comb
    begin
        in_p[0] = point_x;
        in_p[1] = point_y;
        in_p[2] = point_z;
        in_a[0] = start_x;
        in_a[1] = start_y;
        in_a[2] = start_z;
        in_b[0] = end_x;
        in_b[1] = end_y;
        in_b[2] = end_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sa_p_reg[i]  <= in_p[i];
                sa_a_reg[i]  <= in_a[i];
                sa_d_reg[i]  <= psd_pkg::diff_t'(in_b[i]) - psd_pkg::diff_t'(in_a[i]);
                sa_pa_reg[i] <= psd_pkg::diff_t'(in_p[i]) - psd_pkg::diff_t'(in_a[i]);

                sb_p_reg[i]  <= sa_p_reg[i];
                sb_a_reg[i]  <= sa_a_reg[i];
                sb_d_reg[i]  <= sa_d_reg[i];
                sb_dd_reg[i] <= psd_pkg::prod_t'(sa_d_reg[i]) * psd_pkg::prod_t'(sa_d_reg[i]);
                sb_dp_reg[i] <= psd_pkg::prod_t'(sa_d_reg[i]) * psd_pkg::prod_t'(sa_pa_reg[i]);

                sc_p_reg[i]  <= sb_p_reg[i];
                sc_a_reg[i]  <= sb_a_reg[i];
                sc_d_reg[i]  <= sb_d_reg[i];
            end
            sc_len_reg <= psd_pkg::sum_t'(sb_dd_reg[0]) + psd_pkg::sum_t'(sb_dd_reg[1])
                          + psd_pkg::sum_t'(sb_dd_reg[2]);
            sc_dot_reg <= psd_pkg::sum_t'(sb_dp_reg[0]) + psd_pkg::sum_t'(sb_dp_reg[1])
                          + psd_pkg::sum_t'(sb_dp_reg[2]);
        end
    end

    // window [-0.5, 1.5] checked exactly as -len <= 2*dot <= 3*len
    always_comb
    begin
        dot2 = psd_pkg::wide_t'(sc_dot_reg) <<< 1;
        len1 = psd_pkg::wide_t'(sc_len_reg);
        len3 = (len1 <<< 1) + len1;
        sd_next.neg = sc_dot_reg[psd_pkg::SUM_W-1];
        sd_next.p   = sc_p_reg;
        sd_next.a   = sc_a_reg;
        sd_next.d   = sc_d_reg;
        sd_next.den = psd_pkg::usum_t'(sc_len_reg);
        sd_next.rem = sd_next.neg ? psd_pkg::usum_t'(-sc_dot_reg)
                                  : psd_pkg::usum_t'(sc_dot_reg);
        sd_next.quo = '0;
        priority if (sc_len_reg == '0)
        begin
            sd_next.status = psd_pkg::STATUS_DEGEN;
        end
        else if (dot2 < -len1 || dot2 > len3)
        begin
            sd_next.status = psd_pkg::STATUS_WINDOW;
        end
        else
        begin
            sd_next.status = psd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg <= sd_next;
        end
    end

    // restoring division, one quotient bit per stage: integer bit first, then 17 fraction bits
    for (genvar k = 0; k < psd_pkg::QUO_W; k++)
    begin : g_div
        psd_pkg::div_t  src;
        psd_pkg::div_t  div_next;
        psd_pkg::usum_t cand;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign src  = sd_reg;
            assign cand = sd_reg.rem;
        end
        else
        begin : g_rest
            assign src  = div_reg[k-1];
            assign cand = div_reg[k-1].rem << 1;
        end

        assign ge = (cand >= src.den);

        always_comb
        begin
            div_next     = src;
            div_next.rem = ge ? cand - src.den : cand;
            div_next.quo = {src.quo[psd_pkg::QUO_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k] <= div_next;
            end
        end
    end

    // the extra quotient bit rounds to nearest, ties away from zero
    assign t_sum = {1'b0, div_reg[psd_pkg::QUO_W-1].quo} + (psd_pkg::QUO_W+1)'(1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_status_reg <= div_reg[psd_pkg::QUO_W-1].status;
            st_tmag_reg   <= t_sum[psd_pkg::T_W:1];
            for (int i = 0; i < 3; i++)
            begin
                st_p_reg[i]    <= div_reg[psd_pkg::QUO_W-1].p[i];
                st_a_reg[i]    <= div_reg[psd_pkg::QUO_W-1].a[i];
                st_sgn_reg[i]  <= div_reg[psd_pkg::QUO_W-1].neg
                                  ^ div_reg[psd_pkg::QUO_W-1].d[i][psd_pkg::DIFF_W-1];
                st_dmag_reg[i] <= div_reg[psd_pkg::QUO_W-1].d[i][psd_pkg::DIFF_W-1]
                                  ? psd_pkg::DIFF_W'(-div_reg[psd_pkg::QUO_W-1].d[i])
                                  : psd_pkg::DIFF_W'(div_reg[psd_pkg::QUO_W-1].d[i]);
            end

            sm_status_reg <= st_status_reg;
            for (int i = 0; i < 3; i++)
            begin
                sm_p_reg[i]    <= st_p_reg[i];
                sm_a_reg[i]    <= st_a_reg[i];
                sm_sgn_reg[i]  <= st_sgn_reg[i];
                sm_prod_reg[i] <= psd_pkg::TD_W'(st_tmag_reg) * psd_pkg::TD_W'(st_dmag_reg[i]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd_sum[i]  = {1'b0, sm_prod_reg[i]}
                          + ((psd_pkg::TD_W+1)'(1) << (psd_pkg::T_FRAC - 1));
            off_next[i] = psd_pkg::add_t'(rnd_sum[i][psd_pkg::TD_W:psd_pkg::T_FRAC]);
            if (sm_sgn_reg[i])
            begin
                off_next[i] = -off_next[i];
            end
            pos_sum[i] = psd_pkg::add_t'(sn1_a_reg[i]) + sn1_off_reg[i];
            priority if (pos_sum[i] > psd_pkg::add_t'(psd_pkg::COORD_MAX))
            begin
                nr_next[i] = psd_pkg::COORD_MAX;
            end
            else if (pos_sum[i] < psd_pkg::add_t'(psd_pkg::COORD_MIN))
            begin
                nr_next[i] = psd_pkg::COORD_MIN;
            end
            else
            begin
                nr_next[i] = pos_sum[i][psd_pkg::COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn1_status_reg <= sm_status_reg;
            sn2_status_reg <= sn1_status_reg;
            se1_status_reg <= sn2_status_reg;
            se2_status_reg <= se1_status_reg;
            for (int i = 0; i < 3; i++)
            begin
                sn1_p_reg[i]   <= sm_p_reg[i];
                sn1_a_reg[i]   <= sm_a_reg[i];
                sn1_off_reg[i] <= off_next[i];

                sn2_p_reg[i]   <= sn1_p_reg[i];
                sn2_nr_reg[i]  <= nr_next[i];

                se1_nr_reg[i]  <= sn2_nr_reg[i];
                se1_e_reg[i]   <= psd_pkg::diff_t'(sn2_nr_reg[i])
                                  - psd_pkg::diff_t'(sn2_p_reg[i]);

                se2_nr_reg[i]  <= se1_nr_reg[i];
                se2_sq_reg[i]  <= psd_pkg::prod_t'(se1_e_reg[i])
                                  * psd_pkg::prod_t'(se1_e_reg[i]);
            end
            se3_reg.status <= se2_status_reg;
            se3_reg.nr     <= se2_nr_reg;
            se3_reg.rad    <= psd_pkg::usum_t'(se2_sq_reg[0]) + psd_pkg::usum_t'(se2_sq_reg[1])
                              + psd_pkg::usum_t'(se2_sq_reg[2]);
            se3_reg.rem    <= '0;
            se3_reg.root   <= '0;
        end
    end

    // square root, two radicand bits and one root bit per stage
    for (genvar k = 0; k < psd_pkg::ROOT_W; k++)
    begin : g_sqrt
        psd_pkg::sqrt_t           src;
        psd_pkg::sqrt_t           sqrt_next;
        logic [psd_pkg::REM_W-1:0] cand;
        logic [psd_pkg::REM_W-1:0] trial;
        logic                     ge;

        if (k == 0)
        begin : g_first
            assign src = se3_reg;
        end
        else
        begin : g_rest
            assign src = sqrt_reg[k-1];
        end

        assign cand  = {src.rem[psd_pkg::REM_W-3:0], src.rad[psd_pkg::SUM_W-1 -: 2]};
        assign trial = psd_pkg::REM_W'({src.root, 2'b01});
        assign ge    = (cand >= trial);

        always_comb
        begin
            sqrt_next      = src;
            sqrt_next.rad  = src.rad << 2;
            sqrt_next.rem  = ge ? cand - trial : cand;
            sqrt_next.root = {src.root[psd_pkg::ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqrt_reg[k] <= sqrt_next;
            end
        end
    end

    // remainder above the root means the true root is past the half point
    always_comb
    begin
        dist_sum = {1'b0, sqrt_reg[psd_pkg::ROOT_W-1].root}
                   + (psd_pkg::ROOT_W+1)'(sqrt_reg[psd_pkg::ROOT_W-1].rem
                      > psd_pkg::REM_W'(sqrt_reg[psd_pkg::ROOT_W-1].root));
        if (dist_sum > (psd_pkg::ROOT_W+1)'(psd_pkg::DIST_MAX))
        begin
            dist_next = psd_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = psd_pkg::DIST_W'(dist_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_status_reg <= sqrt_reg[psd_pkg::ROOT_W-1].status;
            if (sqrt_reg[psd_pkg::ROOT_W-1].status == psd_pkg::STATUS_OK)
            begin
                out_near_reg <= sqrt_reg[psd_pkg::ROOT_W-1].nr;
                out_dist_reg <= dist_next;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    out_near_reg[i] <= '0;
                end
                out_dist_reg <= '0;
            end
        end
    end

    assign result_valid = vld_reg[NUM_STAGES-1];
    assign status       = out_status_reg;
    assign near_x       = out_near_reg[0];
    assign near_y       = out_near_reg[1];
    assign near_z       = out_near_reg[2];
    assign distance     = out_dist_reg;

endmodule

@@ rtl/psd_checker.sv @@
// port-level checks for point_segment_distance_unit, attached by bind
// depends on psd_pkg

module psd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        query_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input psd_pkg::status_t            status,
    input psd_pkg::coord_t             near_x,
    input psd_pkg::coord_t             near_y,
    input psd_pkg::coord_t             near_z,
    input logic [psd_pkg::DIST_W-1:0]  distance
);

    // a stalled result is still offered next cycle
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // the input only backs up behind a blocked result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> result_valid && result_stall)
        else $error("query stalled without a blocked result");

    // degenerate and out of window results carry no geometry
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != psd_pkg::STATUS_OK
        |-> near_x == '0 && near_y == '0 && near_z == '0 && distance == '0)
        else $error("nonzero result on error status");

endmodule

bind point_segment_distance_unit psd_checker u_psd_checker (.*);

@@ sim/point_segment_distance_unit_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the point to segment distance unit
// depends on psd_pkg and point_segment_distance_unit; directed table then random queries

module point_segment_distance_unit_tb;
    import psd_pkg::*;

    localparam int RANDOM_QUERIES = 450;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct packed {
        coord_t [2:0] pt;
        coord_t [2:0] sa;
        coord_t [2:0] sb;
    } query_t;

    typedef struct packed {
        status_t            st;
        coord_t             nx;
        coord_t             ny;
        coord_t             nz;
        logic [DIST_W-1:0]  dlen;
    } answer_t;

    typedef struct packed {
        query_t  q;
        logic    typed;
        answer_t ans;
    } row_t;

    logic    clk;
    logic    rst_n;
    logic    query_valid;
    logic    query_stall;
    coord_t  point_x, point_y, point_z;
    coord_t  start_x, start_y, start_z;
    coord_t  end_x, end_y, end_z;
    logic    result_valid;
    logic    result_stall;
    status_t status;
    coord_t  near_x, near_y, near_z;
    logic [DIST_W-1:0] distance;

    answer_t pending_answers [$];
    row_t    directed_rows [$];
    logic    failed = 1'b0;
    logic    calm_receiver;
    int      cycle_count;

    point_segment_distance_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_z      (start_z),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_z        (end_z),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .near_x       (near_x),
        .near_y       (near_y),
        .near_z       (near_z),
        .distance     (distance)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic coord_t [2:0] vec(input int x, input int y, input int z);
        coord_t [2:0] v;
        v[0] = coord_t'(x);
        v[1] = coord_t'(y);
        v[2] = coord_t'(z);
        return v;
    endfunction

    // projection, rounding and square root, all in 64-bit integers
    function automatic answer_t closest_on_segment(input query_t q);
        answer_t ans;
        longint p[3], a[3], d[3], nr[3];
        longint len_sq, dot, t, prod, e;
        longint unsigned den, mag, quo, rem, ssq, root, b;
        longint hi, lo;
        ans = '0;
        len_sq = 0;
        dot = 0;
        hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = longint'($signed(q.pt[i]));
            a[i] = longint'($signed(q.sa[i]));
            d[i] = longint'($signed(q.sb[i])) - a[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            len_sq += d[i] * d[i];
            dot += d[i] * (p[i] - a[i]);
        end
        if (len_sq == 0)
        begin
            ans.st = STATUS_DEGEN;
            return ans;
        end
        if (2 * dot < -len_sq || 2 * dot > 3 * len_sq)
        begin
            ans.st = STATUS_WINDOW;
            return ans;
        end
        den = len_sq;
        mag = (dot < 0) ? -dot : dot;
        quo = mag / den;
        rem = mag % den;
        for (int i = 0; i < T_FRAC + 1; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem -= den;
                quo |= 1;
            end
        end
        quo = (quo + 1) >> 1;
        t = (dot < 0) ? -longint'(quo) : longint'(quo);
        ssq = 0;
        for (int i = 0; i < 3; i++)
        begin
            prod = t * d[i];
            mag = (prod < 0) ? -prod : prod;
            mag = (mag + (64'd1 << (T_FRAC - 1))) >> T_FRAC;
            prod = (prod < 0) ? -longint'(mag) : longint'(mag);
            nr[i] = a[i] + prod;
            if (nr[i] > hi)
                nr[i] = hi;
            if (nr[i] < lo)
                nr[i] = lo;
            e = nr[i] - p[i];
            ssq += e * e;
        end
        // digit-by-digit root with round to nearest from the remainder
        root = 0;
        b = 64'd1 << 62;
        while (b > ssq)
            b = b >> 2;
        while (b != 0)
        begin
            if (ssq >= root + b)
            begin
                ssq -= root + b;
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        if (ssq > root)
            root++;
        if (root > DIST_MAX)
            root = DIST_MAX;
        ans.st = STATUS_OK;
        ans.nx = coord_t'(nr[0]);
        ans.ny = coord_t'(nr[1]);
        ans.nz = coord_t'(nr[2]);
        ans.dlen = root[DIST_W-1:0];
        return ans;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int span_coord(input int span);
        return int'($urandom_range(0, 2 * span - 1)) - span;
    endfunction

    function automatic query_t random_query();
        query_t q;
        int r, s;
        r = $urandom_range(0, 99);
        s = (r < 60) ? 4096 : 1 << 20;
        if (r < 75)
        begin
            q.sa = vec(span_coord(s), span_coord(s), span_coord(s));
            q.sb = vec(int'($signed(q.sa[0])) + span_coord(s),
                       int'($signed(q.sa[1])) + span_coord(s),
                       int'($signed(q.sa[2])) + span_coord(s));
            q.pt = vec(int'($signed(q.sa[0])) + span_coord(2 * s),
                       int'($signed(q.sa[1])) + span_coord(2 * s),
                       int'($signed(q.sa[2])) + span_coord(2 * s));
        end
        else
        begin
            q.pt = vec($urandom, $urandom, $urandom);
            q.sa = vec($urandom, $urandom, $urandom);
            q.sb = (r < 92) ? vec($urandom, $urandom, $urandom) : q.sa;
        end
        return q;
    endfunction

    task automatic add_row(input query_t q, input logic typed, input answer_t ans);
        row_t row;
        row.q = q;
        row.typed = typed;
        row.ans = ans;
        directed_rows.push_back(row);
    endtask

    task automatic send_query(input query_t q, input answer_t ans);
        int gap;
        gap = calm_receiver ? 0 : idle_length();
        if (gap > 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        query_valid <= 1'b1;
        point_x <= q.pt[0];
        point_y <= q.pt[1];
        point_z <= q.pt[2];
        start_x <= q.sa[0];
        start_y <= q.sa[1];
        start_z <= q.sa[2];
        end_x <= q.sb[0];
        end_y <= q.sb[1];
        end_z <= q.sb[2];
        forever
        begin
            @(posedge clk);
            if (!query_stall)
                break;
        end
        pending_answers.push_back(ans);
        @(negedge clk);
    endtask

    // receiver side: random stall, with calm stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (calm_receiver)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < 30);
    end

    always @(posedge clk)
    begin
        answer_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t unexpected result transfer", $time);
                failed <= 1'b1;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t status exp %0d got %0d", $time, want.st, status);
                    failed <= 1'b1;
                end
                if (near_x !== want.nx)
                begin
                    $display("%0t near_x exp %0d got %0d", $time, want.nx, near_x);
                    failed <= 1'b1;
                end
                if (near_y !== want.ny)
                begin
                    $display("%0t near_y exp %0d got %0d", $time, want.ny, near_y);
                    failed <= 1'b1;
                end
                if (near_z !== want.nz)
                begin
                    $display("%0t near_z exp %0d got %0d", $time, want.nz, near_z);
                    failed <= 1'b1;
                end
                if (distance !== want.dlen)
                begin
                    $display("%0t distance exp %0d got %0d", $time, want.dlen, distance);
                    failed <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        answer_t zero_ok, degen, window, ans;
        query_t q;
        int cmax, cmin;
        calm_receiver = 1'b0;
        rst_n = 1'b0;
        query_valid = 1'b0;
        {point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z} = '0;
        cmax = int'(COORD_MAX);
        cmin = int'($signed(COORD_MIN));
        zero_ok = '0;
        degen = '0;
        degen.st = STATUS_DEGEN;
        window = '0;
        window.st = STATUS_WINDOW;

        // degenerate segments, zeros and extremes
        add_row({vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, 0)}, 1'b1, degen);
        add_row({vec(cmax, cmin, cmax), vec(cmin, cmin, cmin), vec(cmin, cmin, cmin)},
                1'b1, degen);
        add_row({vec(5, 6, 7), vec(cmax, cmax, cmax), vec(cmax, cmax, cmax)}, 1'b1, degen);
        // point at the start: t = 0, distance zero
        ans = zero_ok;
        ans.nx = 100; ans.ny = -200; ans.nz = 300;
        add_row({vec(100, -200, 300), vec(100, -200, 300), vec(900, 50, -70)}, 1'b1, ans);
        // full-range diagonal, point at the end
        ans = zero_ok;
        ans.nx = cmax; ans.ny = cmax; ans.nz = cmax;
        add_row({vec(cmax, cmax, cmax), vec(cmin, cmin, cmin), vec(cmax, cmax, cmax)},
                1'b1, ans);
        // window ends are accepted
        ans = zero_ok;
        ans.nx = -256;
        add_row({vec(-256, 0, 0), vec(0, 0, 0), vec(512, 0, 0)}, 1'b1, ans);
        ans = zero_ok;
        ans.nx = 768;
        add_row({vec(768, 0, 0), vec(0, 0, 0), vec(512, 0, 0)}, 1'b1, ans);
        // just past either window end
        add_row({vec(-257, 0, 0), vec(0, 0, 0), vec(512, 0, 0)}, 1'b1, window);
        add_row({vec(769, 0, 0), vec(0, 0, 0), vec(512, 0, 0)}, 1'b1, window);
        add_row({vec(cmin, cmin, cmin), vec(0, 0, 0), vec(cmax, cmax, cmax)}, 1'b1, window);
        // saturation of the closest point, off-line points, rounding
        add_row({vec(cmax, cmax, cmax), vec(0, 0, 0), vec(cmax, 0, 0)}, 1'b0, zero_ok);
        add_row({vec(cmin, 0, cmax), vec(0, 0, 0), vec(cmin, 1, 0)}, 1'b0, zero_ok);
        add_row({vec(1000, 777, -3), vec(1, 2, 3), vec(3, 5, 7)}, 1'b0, zero_ok);
        add_row({vec(-1, -1, -1), vec(0, 0, 0), vec(3, 0, 0)}, 1'b0, zero_ok);
        add_row({vec(cmin, cmax, cmin), vec(cmax, cmin, 0), vec(cmin, cmax, 1)},
                1'b0, zero_ok);
        add_row({vec(2, 1, 0), vec(0, 0, 0), vec(3, 7, 11)}, 1'b0, zero_ok);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_query(directed_rows[i].q,
                       directed_rows[i].typed ? directed_rows[i].ans
                                              : closest_on_segment(directed_rows[i].q));

        for (int n = 0; n < RANDOM_QUERIES; n++)
        begin
            // back-to-back stretches with no idling on either side
            if (n % 100 == 0)
                calm_receiver = 1'b1;
            else if (n % 100 == 30)
                calm_receiver = 1'b0;
            q = random_query();
            send_query(q, closest_on_segment(q));
        end
        query_valid <= 1'b0;
        calm_receiver = 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ point_segment_distance_unit.f @@
rtl/psd_pkg.sv
rtl/point_segment_distance_unit.sv
rtl/psd_checker.sv
sim/point_segment_distance_unit_tb.sv
